FILE: rtl/core/edf_pkg.sv
// Package with the shared constants and types of the EDF periodic task scheduler.
`default_nettype none

package edf_pkg;

    localparam int MAX_TASKS = 8;
    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int LANE_W = $clog2(MAX_TASKS + 1);

    localparam logic [LANE_W-1:0] MAX_LANES = LANE_W'(MAX_TASKS);
    localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;
    localparam logic [15:0] U16_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RUN,
        ST_WAIT,
        ST_BOUND,
        ST_DONE,
        ST_FINISH
    } state_t;

    localparam logic REG_ACTIVE_TASKS = 1'b0;

endpackage

`default_nettype wire

FILE: rtl/core/edf_periodic_task_scheduler.sv
// Top level of the EDF periodic task scheduler: sequencer, task tables and APB register.
//
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   cmd, task_slot, exec_time, period_len, job_count
// output    out        out_valid/out_stall run_valid .. jobs_ended
// config    APB        psel/penable        active_tasks at byte address 0
//
// A tick makes one pass over the active slots for the deadline scan, one for waiting time
// and release checks, with a WAIT and a BOUND state per slot, and one for the completion
// check, all through one shared compare and add path. A load, a query or a no-operation
// command makes only the completion pass.
// Reset is asynchronous, clears the ready bits, time and miss count, and sets the register to one.
// The block accepts a new command while a result still waits under stall.
`default_nettype none

module edf_periodic_task_scheduler
    import edf_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,

    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [1:0]    cmd,
    input  wire logic [2:0]    task_slot,
    input  wire logic [15:0]   exec_time,
    input  wire logic [15:0]   period_len,
    input  wire logic [15:0]   job_count,

    output logic               out_valid,
    input  wire logic          out_stall,
    output logic               run_valid,
    output logic [2:0]         run_slot,
    output logic               job_finished,
    output logic [7:0]         miss_mask,
    output logic [31:0]        miss_total,
    output logic               all_done,
    output logic [31:0]        now_time,
    output logic [31:0]        wait_total,
    output logic [15:0]        jobs_ended
);

    state_t state_reg, state_next;

    logic [LANE_W-1:0]    cnt_reg;
    logic [3:0]           active_reg;
    logic [MAX_TASKS-1:0] ready_reg;
    logic [31:0]          time_reg;
    logic [31:0]          miss_reg;
    logic                 out_valid_reg;

    logic [15:0] exec_reg     [MAX_TASKS];
    logic [15:0] period_reg   [MAX_TASKS];
    logic [15:0] count_reg    [MAX_TASKS];
    logic [15:0] remain_reg   [MAX_TASKS];
    logic [31:0] deadline_reg [MAX_TASKS];
    logic [31:0] release_reg  [MAX_TASKS];
    logic [15:0] releases_reg [MAX_TASKS];
    logic [31:0] wait_reg     [MAX_TASKS];
    logic [15:0] ended_reg    [MAX_TASKS];

    logic              found_reg;
    logic [SLOT_W-1:0] run_reg;
    logic [31:0]       best_reg;
    logic              fin_reg;
    logic [7:0]        mask_reg;
    logic              adv_reg;
    logic              hit_reg;
    logic              done_reg;
    logic [31:0]       qwait_reg;
    logic [15:0]       qended_reg;

    logic              o_run_valid_reg;
    logic [2:0]        o_run_slot_reg;
    logic              o_fin_reg;
    logic [7:0]        o_mask_reg;
    logic [31:0]       o_miss_reg;
    logic              o_done_reg;
    logic [31:0]       o_time_reg;
    logic [31:0]       o_wait_reg;
    logic [15:0]       o_ended_reg;

    logic              in_fire;
    logic              out_fire;
    logic              cfg_write;
    logic [LANE_W-1:0] lanes;
    logic              loop_more;
    logic [SLOT_W-1:0] ai;
    logic [32:0]       release_sum;
    logic [31:0]       release_new;
    logic [32:0]       load_sum;
    logic [31:0]       load_deadline;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_TASKS);
    assign prdata    = (paddr[2] == REG_ACTIVE_TASKS) ? {28'd0, active_reg} : 32'd0;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_fire  = (state_reg == ST_FINISH) && (!out_valid_reg || !out_stall);

    assign lanes     = (int'(active_reg) > MAX_TASKS) ? MAX_LANES : LANE_W'(active_reg);
    assign loop_more = (cnt_reg < lanes);

    always_comb
    begin
        case (state_reg)
            ST_IDLE: ai = SLOT_W'(task_slot);
            ST_RUN:  ai = run_reg;
            default: ai = cnt_reg[SLOT_W-1:0];
        endcase
    end

    assign release_sum   = {1'b0, release_reg[ai]} + {17'd0, period_reg[ai]};
    assign release_new   = release_sum[32] ? U32_MAX : release_sum[31:0];
    assign load_sum      = {1'b0, time_reg} + {17'd0, period_len};
    assign load_deadline = load_sum[32] ? U32_MAX : load_sum[31:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (cmd_t'(cmd) == CMD_TICK) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:   state_next = loop_more ? ST_SCAN : ST_RUN;
            ST_RUN:    state_next = ST_WAIT;
            ST_WAIT:   state_next = loop_more ? ST_BOUND : ST_DONE;
            ST_BOUND:  state_next = ST_WAIT;
            ST_DONE:   state_next = loop_more ? ST_DONE : ST_FINISH;
            ST_FINISH: state_next = out_fire ? ST_IDLE : ST_FINISH;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            active_reg    <= 4'd1;
            ready_reg     <= '0;
            time_reg      <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                active_reg <= pwdata[3:0];
            end
            if (out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_fire && (cmd_t'(cmd) == CMD_LOAD))
                    begin
                        ready_reg[ai] <= 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    cnt_reg <= loop_more ? cnt_reg + LANE_W'(1) : '0;
                end
                ST_RUN:
                begin
                    if (found_reg && (remain_reg[ai] <= 16'd1))
                    begin
                        ready_reg[ai] <= 1'b0;
                    end
                    if (time_reg != U32_MAX)
                    begin
                        time_reg <= time_reg + 32'd1;
                    end
                end
                ST_WAIT:
                begin
                    if (!loop_more)
                    begin
                        cnt_reg <= '0;
                    end
                end
                ST_BOUND:
                begin
                    if (hit_reg)
                    begin
                        if (ready_reg[ai] && (miss_reg != U32_MAX))
                        begin
                            miss_reg <= miss_reg + 32'd1;
                        end
                        ready_reg[ai] <= (releases_reg[ai] < count_reg[ai]);
                    end
                    cnt_reg <= cnt_reg + LANE_W'(1);
                end
                ST_DONE:
                begin
                    if (loop_more)
                    begin
                        cnt_reg <= cnt_reg + LANE_W'(1);
                    end
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    found_reg  <= 1'b0;
                    fin_reg    <= 1'b0;
                    mask_reg   <= '0;
                    done_reg   <= 1'b1;
                    qwait_reg  <= '0;
                    qended_reg <= '0;
                    run_reg    <= '0;
                    case (cmd_t'(cmd))
                        CMD_LOAD:
                        begin
                            exec_reg[ai]     <= exec_time;
                            period_reg[ai]   <= period_len;
                            count_reg[ai]    <= job_count;
                            remain_reg[ai]   <= exec_time;
                            deadline_reg[ai] <= load_deadline;
                            release_reg[ai]  <= load_deadline;
                            releases_reg[ai] <= 16'd1;
                            wait_reg[ai]     <= '0;
                            ended_reg[ai]    <= '0;
                        end
                        CMD_QUERY:
                        begin
                            qwait_reg  <= wait_reg[ai];
                            qended_reg <= ended_reg[ai];
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (loop_more && ready_reg[ai] && (!found_reg || (deadline_reg[ai] <= best_reg)))
                begin
                    found_reg <= 1'b1;
                    run_reg   <= ai;
                    best_reg  <= deadline_reg[ai];
                end
            end
            ST_RUN:
            begin
                adv_reg <= (time_reg != U32_MAX);
                if (found_reg)
                begin
                    if (remain_reg[ai] <= 16'd1)
                    begin
                        remain_reg[ai] <= exec_reg[ai];
                        if (ended_reg[ai] != U16_MAX)
                        begin
                            ended_reg[ai] <= ended_reg[ai] + 16'd1;
                        end
                        fin_reg <= 1'b1;
                    end
                    else
                    begin
                        remain_reg[ai] <= remain_reg[ai] - 16'd1;
                    end
                end
            end
            ST_WAIT:
            begin
                if (loop_more)
                begin
                    if (ready_reg[ai] && !(found_reg && (ai == run_reg))
                        && (wait_reg[ai] != U32_MAX))
                    begin
                        wait_reg[ai] <= wait_reg[ai] + 32'd1;
                    end
                    hit_reg <= adv_reg && (time_reg == release_reg[ai]);
                end
            end
            ST_BOUND:
            begin
                if (hit_reg)
                begin
                    if (ready_reg[ai])
                    begin
                        mask_reg[ai]   <= 1'b1;
                        remain_reg[ai] <= exec_reg[ai];
                        if (ended_reg[ai] != U16_MAX)
                        begin
                            ended_reg[ai] <= ended_reg[ai] + 16'd1;
                        end
                    end
                    if (releases_reg[ai] < count_reg[ai])
                    begin
                        releases_reg[ai] <= releases_reg[ai] + 16'd1;
                        release_reg[ai]  <= release_new;
                        deadline_reg[ai] <= release_new;
                    end
                end
            end
            ST_DONE:
            begin
                if (loop_more && (ready_reg[ai] || (ended_reg[ai] != count_reg[ai])))
                begin
                    done_reg <= 1'b0;
                end
            end
            ST_FINISH:
            begin
                if (out_fire)
                begin
                    o_run_valid_reg <= found_reg;
                    o_run_slot_reg  <= 3'(run_reg);
                    o_fin_reg       <= fin_reg;
                    o_mask_reg      <= mask_reg;
                    o_miss_reg      <= miss_reg;
                    o_done_reg      <= done_reg;
                    o_time_reg      <= time_reg;
                    o_wait_reg      <= qwait_reg;
                    o_ended_reg     <= qended_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign run_valid    = o_run_valid_reg;
    assign run_slot     = o_run_slot_reg;
    assign job_finished = o_fin_reg;
    assign miss_mask    = o_mask_reg;
    assign miss_total   = o_miss_reg;
    assign all_done     = o_done_reg;
    assign now_time     = o_time_reg;
    assign wait_total   = o_wait_reg;
    assign jobs_ended   = o_ended_reg;

    // A transfer in always leaves the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) in_fire |=> in_stall)
        else $error("block took a command but did not go busy");

    // A job can only finish on a tick at which a task ran.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && job_finished) |-> run_valid)
        else $error("job finished without a running task");

    // The miss count never goes backwards.
    assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |=> (miss_reg >= $past(miss_reg)))
        else $error("miss count decreased");

    // The slot loop counter never passes the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= MAX_LANES)
        else $error("slot counter out of range");

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the EDF periodic task scheduler.
`timescale 1ns / 1ps

module tb_top
    import edf_pkg::*;
();

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 50;

    typedef struct packed {
        logic        run_valid;
        logic [2:0]  run_slot;
        logic        job_finished;
        logic [7:0]  miss_mask;
        logic [31:0] miss_total;
        logic        all_done;
        logic [31:0] now_time;
        logic [31:0] wait_total;
        logic [15:0] jobs_ended;
    } sched_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = '0;
    logic [2:0]  task_slot = '0;
    logic [15:0] exec_time = '0;
    logic [15:0] period_len = '0;
    logic [15:0] job_count = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        run_valid;
    logic [2:0]  run_slot;
    logic        job_finished;
    logic [7:0]  miss_mask;
    logic [31:0] miss_total;
    logic        all_done;
    logic [31:0] now_time;
    logic [31:0] wait_total;
    logic [15:0] jobs_ended;

    // Scheduler state as the testbench expects it.
    logic [15:0] task_exec [MAX_TASKS];
    logic [15:0] task_period [MAX_TASKS];
    logic [15:0] task_jobs [MAX_TASKS];
    logic [15:0] task_left [MAX_TASKS];
    logic [15:0] task_released [MAX_TASKS];
    logic [15:0] task_ended [MAX_TASKS];
    logic [31:0] task_deadline [MAX_TASKS];
    logic [31:0] task_release_at [MAX_TASKS];
    logic [31:0] task_wait [MAX_TASKS];
    logic [7:0]  task_ready = '0;
    logic [31:0] clock_now = '0;
    logic [31:0] missed_count = '0;
    logic [3:0]  lanes_cfg = 4'd1;

    sched_result_t expected_results [$];

    bit idle_on = 1'b1;
    int stall_left = 0;
    int cycle_count = 0;
    int error_count = 0;
    int commands_sent = 0;
    int ticks_sent = 0;
    int jobs_completed = 0;
    int misses_seen = 0;
    int done_reports = 0;

    edf_periodic_task_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .task_slot(task_slot),
        .exec_time(exec_time), .period_len(period_len), .job_count(job_count),
        .out_valid(out_valid), .out_stall(out_stall), .run_valid(run_valid),
        .run_slot(run_slot), .job_finished(job_finished), .miss_mask(miss_mask),
        .miss_total(miss_total), .all_done(all_done), .now_time(now_time),
        .wait_total(wait_total), .jobs_ended(jobs_ended)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] add_sat32(logic [31:0] a, logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? U32_MAX : sum[31:0];
    endfunction

    function automatic logic [15:0] inc_sat16(logic [15:0] a);
        return (a == U16_MAX) ? a : a + 16'd1;
    endfunction

    function automatic int lane_count();
        return (int'(lanes_cfg) > MAX_TASKS) ? MAX_TASKS : int'(lanes_cfg);
    endfunction

    function automatic logic tasks_all_done();
        for (int i = 0; i < lane_count(); i++)
        begin
            if (task_ready[i] || task_ended[i] != task_jobs[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic sched_result_t schedule_step(cmd_t c, logic [2:0] s, logic [15:0] e,
                                                    logic [15:0] p, logic [15:0] k);
        sched_result_t r;
        int n;
        int pick;
        bit found;
        bit advanced;
        r = '0;
        n = lane_count();
        pick = 0;
        found = 1'b0;
        advanced = 1'b0;
        case (c)
            CMD_LOAD:
            begin
                task_exec[s] = e;
                task_period[s] = p;
                task_jobs[s] = k;
                task_left[s] = e;
                task_deadline[s] = add_sat32(clock_now, {16'd0, p});
                task_release_at[s] = task_deadline[s];
                task_released[s] = 16'd1;
                task_wait[s] = '0;
                task_ended[s] = '0;
                task_ready[s] = 1'b1;
            end
            CMD_TICK:
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (task_ready[i] && (!found || task_deadline[i] <= task_deadline[pick]))
                    begin
                        pick = i;
                        found = 1'b1;
                    end
                end
                if (found)
                begin
                    r.run_valid = 1'b1;
                    r.run_slot = pick[2:0];
                    if (task_left[pick] <= 16'd1)
                    begin
                        task_ready[pick] = 1'b0;
                        task_left[pick] = task_exec[pick];
                        task_ended[pick] = inc_sat16(task_ended[pick]);
                        r.job_finished = 1'b1;
                    end
                    else
                    begin
                        task_left[pick] = task_left[pick] - 16'd1;
                    end
                end
                if (clock_now != U32_MAX)
                begin
                    clock_now = clock_now + 32'd1;
                    advanced = 1'b1;
                end
                for (int i = 0; i < n; i++)
                begin
                    if (task_ready[i] && !(found && i == pick))
                        task_wait[i] = add_sat32(task_wait[i], 32'd1);
                end
                if (advanced)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        if (clock_now == task_release_at[i])
                        begin
                            if (task_ready[i])
                            begin
                                r.miss_mask[i] = 1'b1;
                                missed_count = add_sat32(missed_count, 32'd1);
                                task_ended[i] = inc_sat16(task_ended[i]);
                                task_ready[i] = 1'b0;
                                task_left[i] = task_exec[i];
                            end
                            if (task_released[i] < task_jobs[i])
                            begin
                                task_ready[i] = 1'b1;
                                task_released[i] = inc_sat16(task_released[i]);
                                task_release_at[i] =
                                    add_sat32(task_release_at[i], {16'd0, task_period[i]});
                                task_deadline[i] = task_release_at[i];
                            end
                        end
                    end
                end
            end
            CMD_QUERY:
            begin
                r.wait_total = task_wait[s];
                r.jobs_ended = task_ended[s];
            end
            default:
            begin
            end
        endcase
        r.miss_total = missed_count;
        r.all_done = tasks_all_done();
        r.now_time = clock_now;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        error_count++;
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    endtask

    task automatic compare_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : result_check
        sched_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("transfer with no result pending", 32'd0, 32'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("run_valid", 32'(run_valid), 32'(want.run_valid));
                compare_field("run_slot", 32'(run_slot), 32'(want.run_slot));
                compare_field("job_finished", 32'(job_finished), 32'(want.job_finished));
                compare_field("miss_mask", 32'(miss_mask), 32'(want.miss_mask));
                compare_field("miss_total", miss_total, want.miss_total);
                compare_field("all_done", 32'(all_done), 32'(want.all_done));
                compare_field("now_time", now_time, want.now_time);
                compare_field("wait_total", wait_total, want.wait_total);
                compare_field("jobs_ended", 32'(jobs_ended), 32'(want.jobs_ended));
            end
        end
    end

    task automatic send_command(cmd_t c, logic [2:0] s, logic [15:0] e,
                                logic [15:0] p, logic [15:0] k);
        sched_result_t r;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        task_slot <= s;
        exec_time <= e;
        period_len <= p;
        job_count <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = schedule_step(c, s, e, p, k);
        expected_results.push_back(r);
        commands_sent++;
        if (c == CMD_TICK)
            ticks_sent++;
        jobs_completed += int'(r.job_finished);
        misses_seen += $countones(r.miss_mask);
        done_reports += int'(r.all_done);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The register is only written with the scheduler idle, then read back.
    task automatic write_active_tasks(logic [3:0] value);
        wait_for_drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_ACTIVE_TASKS, 2'b00};
        pwdata <= {28'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        lanes_cfg = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        compare_field("active_tasks read back", prdata, {28'd0, value});
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_random_load(logic [2:0] s);
        if ($urandom_range(0, 6) == 0)
            send_command(CMD_LOAD, s, 16'($urandom), 16'($urandom), 16'($urandom));
        else
            send_command(CMD_LOAD, s, 16'($urandom_range(0, 5)), 16'($urandom_range(0, 20)),
                         16'($urandom_range(0, 6)));
    endtask

    // Slot 0 is loaded first, so no command ever sees an active slot that was never loaded.
    task automatic test_initial_loads();
        send_command(CMD_LOAD, 3'd0, 16'd2, 16'd5, 16'd3);
        send_command(CMD_LOAD, 3'd1, 16'd0, 16'd4, 16'd2);
        send_command(CMD_LOAD, 3'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_command(CMD_LOAD, 3'd3, 16'd1, 16'd0, 16'd1);
        send_command(CMD_LOAD, 3'd4, 16'd3, 16'd3, 16'd0);
        send_command(CMD_LOAD, 3'd5, 16'd1, 16'd1, 16'd1);
        send_command(CMD_LOAD, 3'd6, 16'd2, 16'd6, 16'd1);
        send_command(CMD_LOAD, 3'd7, 16'd1, 16'd4, 16'd4);
    endtask

    // Equal deadlines on slots 1 and 7 check the tie rule; slot 4 misses with no jobs left.
    task automatic test_edf_directed();
        write_active_tasks(4'd8);
        repeat (6) send_command(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
        send_command(CMD_QUERY, 3'd4, 16'd0, 16'd0, 16'd0);
        send_command(CMD_QUERY, 3'd2, 16'd0, 16'd0, 16'd0);
        send_command(CMD_NOP, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    task automatic test_register_extremes();
        write_active_tasks(4'd15);
        send_command(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
        write_active_tasks(4'd0);
        send_command(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
        send_command(CMD_QUERY, 3'd0, 16'd0, 16'd0, 16'd0);
        send_command(CMD_NOP, 3'd0, 16'd0, 16'd0, 16'd0);
        write_active_tasks(4'd1);
        send_command(CMD_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
    endtask

    // A phase reloads every active slot with a short task set and then mostly ticks it.
    task automatic test_random_scheduling(logic [3:0] active, int count, bit with_idle);
        int n;
        int pick;
        idle_on = with_idle;
        write_active_tasks(active);
        n = (int'(active) > MAX_TASKS) ? MAX_TASKS : int'(active);
        for (int i = 0; i < n; i++)
            send_random_load(i[2:0]);
        for (int i = n; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                send_command(CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
            else if (pick < 77)
                send_random_load(3'($urandom));
            else if (pick < 92)
                send_command(CMD_QUERY, 3'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
            else
                send_command(CMD_NOP, 3'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_initial_loads();
        test_edf_directed();
        test_register_extremes();
        test_random_scheduling(4'd8, 125, 1'b1);
        test_random_scheduling(4'($urandom_range(1, 7)), 125, 1'b1);
        test_random_scheduling(4'd15, 125, 1'b1);
        test_random_scheduling(4'($urandom_range(1, 15)), 125, 1'b1);
        test_random_scheduling(4'd8, 125, 1'b0);
        wait_for_drain();
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", 32'(expected_results.size()), 32'd0);
        $display("summary: %0d commands, %0d ticks, %0d jobs completed", commands_sent,
                 ticks_sent, jobs_completed);
        $display("summary: %0d deadline misses, %0d all-done reports, %0d mismatches",
                 misses_seen, done_reports, error_count);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
